// ----- src/rmq_pkg.sv -----
// Shared constants for the rotation matrix to quaternion core.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int unsigned DataWidth = 24;
  localparam int unsigned FracBits  = 16;

  localparam logic [2:0] PathIdent = 3'd0;
  localparam logic [2:0] PathTrace = 3'd1;
  localparam logic [2:0] PathX     = 3'd2;
  localparam logic [2:0] PathY     = 3'd3;
  localparam logic [2:0] PathZ     = 3'd4;

endpackage
`default_nettype wire

// ----- src/rmq_sqrt_stage.sv -----
// One registered step of the bitwise square root, with pipeline payload.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_stage #(
  parameter int unsigned RW  = 40,
  parameter int unsigned YW  = 20,
  parameter int unsigned PW  = 8,
  parameter int unsigned BIT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [RW-1:0] rad_i,
  input  wire logic [YW-1:0] root_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               valid_o,
  output logic [RW-1:0]      rad_o,
  output logic [YW-1:0]      root_o,
  output logic [PW-1:0]      pay_o
);
  logic [YW-1:0]   cand;
  logic [2*YW-1:0] sq;
  logic [YW-1:0]   root_d;

  always_comb begin
    cand = root_i | (YW'(1) << BIT);
    sq = {{YW{1'b0}}, cand} * {{YW{1'b0}}, cand};
    root_d = ((2*YW) > RW) ? ((sq <= (2*YW)'(rad_i)) ? cand : root_i)
                           : ((RW'(sq) <= rad_i) ? cand : root_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i;
      root_o <= root_d;
      pay_o  <= pay_i;
    end
  end
endmodule
`default_nettype wire

// ----- src/rmq_div_stage.sv -----
// One registered restoring division step for three shared-divisor quotients.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_stage #(
  parameter int unsigned NW  = 40,
  parameter int unsigned SW  = 20,
  parameter int unsigned PW  = 8,
  parameter int unsigned BIT = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [SW-1:0]   div_i,
  input  wire logic [3*NW-1:0] num_i,
  input  wire logic [3*SW-1:0] rem_i,
  input  wire logic [3*NW-1:0] quo_i,
  input  wire logic [PW-1:0]   pay_i,
  output logic                 valid_o,
  output logic [SW-1:0]        div_o,
  output logic [3*NW-1:0]      num_o,
  output logic [3*SW-1:0]      rem_o,
  output logic [3*NW-1:0]      quo_o,
  output logic [PW-1:0]        pay_o
);
  logic [3*SW-1:0] rem_d;
  logic [3*NW-1:0] quo_d;
  logic [SW:0]     t;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    t = '0;
    for (int k = 0; k < 3; k++) begin
      t = {rem_i[k*SW +: SW], num_i[k*NW + BIT]};
      if (t >= {1'b0, div_i}) begin
        t = t - {1'b0, div_i};
        quo_d[k*NW + BIT] = 1'b1;
      end
      rem_d[k*SW +: SW] = t[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o <= div_i;
      num_o <= num_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
      pay_o <= pay_i;
    end
  end
endmodule
`default_nettype wire

// ----- src/rotation_matrix_to_quaternion_core.sv -----
// Top level: scale, branch select, square root and division pipeline.
// Fully pipelined core: one matrix enters per cycle unless stalled, and passes through
// 2 + (DATA_WIDTH+FRAC_BITS+4)/2 square root stages + DATA_WIDTH+FRAC_BITS+3
// division stages + 1 output stage (68 register stages at the defaults). The depth
// is set by the one-bit-per-stage square root and quotient recurrences. A global
// stall freezes every stage; in_stall_o follows out_stall_i while the output
// register holds a result.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FracBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] m00_i,
  input  wire logic signed [DATA_WIDTH-1:0] m01_i,
  input  wire logic signed [DATA_WIDTH-1:0] m02_i,
  input  wire logic signed [DATA_WIDTH-1:0] m10_i,
  input  wire logic signed [DATA_WIDTH-1:0] m11_i,
  input  wire logic signed [DATA_WIDTH-1:0] m12_i,
  input  wire logic signed [DATA_WIDTH-1:0] m20_i,
  input  wire logic signed [DATA_WIDTH-1:0] m21_i,
  input  wire logic signed [DATA_WIDTH-1:0] m22_i,
  input  wire logic signed [DATA_WIDTH-1:0] scale_x_i,
  input  wire logic signed [DATA_WIDTH-1:0] scale_y_i,
  input  wire logic signed [DATA_WIDTH-1:0] scale_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0]      quat_w_o,
  output logic signed [DATA_WIDTH-1:0]      quat_x_o,
  output logic signed [DATA_WIDTH-1:0]      quat_y_o,
  output logic signed [DATA_WIDTH-1:0]      quat_z_o,
  output logic [2:0]                        path_o,
  output logic                              degenerate_o
);
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned PWD = 2*DW;
  localparam int unsigned EW  = DW + 3;
  localparam int unsigned RW  = EW + FB;
  localparam int unsigned YW  = (RW + 1) / 2;
  localparam int unsigned SW  = YW + 1;
  localparam int unsigned NW  = EW + FB;
  localparam int unsigned PW  = 3*EW + 3 + 3 + 1 + 2;
  localparam logic signed [DW-1:0] MaxV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MinV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [EW-1:0] OneE = EW'(1) << FB;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: products
  logic signed [DW-1:0] mi [9];
  logic signed [DW-1:0] si [3];
  logic signed [PWD-1:0] p_q [9];
  logic v1_q;
  assign mi = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};
  assign si = '{scale_x_i, scale_y_i, scale_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) for (int k = 0; k < 9; k++) p_q[k] <= PWD'(mi[k]) * PWD'(si[k % 3]);
  end

  function automatic logic signed [DW-1:0] fxs(input logic signed [PWD-1:0] p);
    logic [PWD-1:0] m;
    logic [PWD-1:0] t;
    logic neg;
    neg = p[PWD-1];
    m = neg ? PWD'(-p) : PWD'(p);
    t = m >> FB;
    if (t > PWD'(MaxV)) return neg ? MinV : MaxV;
    return neg ? DW'(-t) : DW'(t);
  endfunction

  // stage 2: scaled elements, branch, radicand, numerators
  logic signed [EW-1:0] e [9];
  logic signed [EW-1:0] tr, rad, d1, d2, d3;
  logic [2:0] path_d;
  logic ident;
  always_comb begin
    for (int k = 0; k < 9; k++) e[k] = EW'(fxs(p_q[k]));
    tr = e[0] + e[4] + e[8];
    ident = (e[0] == OneE) && (e[4] == OneE) && (e[8] == OneE);
    if (tr >= 0) begin
      path_d = rmq_pkg::PathTrace; rad = tr + OneE;
      d1 = e[7] - e[5]; d2 = e[2] - e[6]; d3 = e[3] - e[1];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      path_d = rmq_pkg::PathX; rad = OneE + e[0] - e[4] - e[8];
      d1 = e[7] - e[5]; d2 = e[1] + e[3]; d3 = e[6] + e[2];
    end else if (e[4] > e[8]) begin
      path_d = rmq_pkg::PathY; rad = OneE - e[0] + e[4] - e[8];
      d1 = e[2] - e[6]; d2 = e[1] + e[3]; d3 = e[5] + e[7];
    end else begin
      path_d = rmq_pkg::PathZ; rad = OneE - e[0] - e[4] + e[8];
      d1 = e[3] - e[1]; d2 = e[6] + e[2]; d3 = e[5] + e[7];
    end
    if (ident) path_d = rmq_pkg::PathIdent;
  end

  logic v2_q;
  logic [RW-1:0] rad_q;
  logic [PW-1:0] pay2_q;
  logic dg;
  assign dg = !ident && (rad <= 0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= dg ? '0 : {rad, {FB{1'b0}}};
      pay2_q <= {d1, d2, d3, path_d, ident ? 3'd0 : path_d - 3'd1, dg, 2'b00};
    end
  end

  // square root chain
  logic          sv [YW+1];
  logic [RW-1:0] sr [YW+1];
  logic [YW-1:0] sy [YW+1];
  logic [PW-1:0] sp [YW+1];
  assign sv[0] = v2_q;
  assign sr[0] = rad_q;
  assign sy[0] = '0;
  assign sp[0] = pay2_q;
  for (genvar g = 0; g < YW; g++) begin : g_sqrt
    rmq_sqrt_stage #(.RW(RW), .YW(YW), .PW(PW), .BIT(YW-1-g)) u_st (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sv[g]), .rad_i(sr[g]), .root_i(sy[g]),
      .pay_i(sp[g]), .valid_o(sv[g+1]), .rad_o(sr[g+1]), .root_o(sy[g+1]),
      .pay_o(sp[g+1]));
  end

  // numerator magnitudes and divisor
  localparam int unsigned PP = PW;
  logic [3*NW-1:0] num0;
  logic [2:0]      sgn;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [EW-1:0] dv;
      logic [EW-1:0] mg;
      dv = sp[YW][PP-1-k*EW -: EW];
      mg = dv[EW-1] ? EW'(-dv) : EW'(dv);
      sgn[k] = dv[EW-1];
      num0[k*NW +: NW] = {mg, {FB{1'b0}}};
    end
  end

  logic          dv_v [NW+1];
  logic [SW-1:0] dv_s [NW+1];
  logic [3*NW-1:0] dv_n [NW+1];
  logic [3*SW-1:0] dv_r [NW+1];
  logic [3*NW-1:0] dv_q [NW+1];
  logic [PW+YW+3-1:0] dv_p [NW+1];
  assign dv_v[0] = sv[YW];
  assign dv_s[0] = {sy[YW], 1'b0};
  assign dv_n[0] = num0;
  assign dv_r[0] = '0;
  assign dv_q[0] = '0;
  assign dv_p[0] = {sp[YW], sy[YW], sgn};
  for (genvar g = 0; g < NW; g++) begin : g_div
    rmq_div_stage #(.NW(NW), .SW(SW), .PW(PW+YW+3), .BIT(NW-1-g)) u_dv (
      .clk_i, .rst_ni, .en_i(en), .valid_i(dv_v[g]), .div_i(dv_s[g]), .num_i(dv_n[g]),
      .rem_i(dv_r[g]), .quo_i(dv_q[g]), .pay_i(dv_p[g]), .valid_o(dv_v[g+1]),
      .div_o(dv_s[g+1]), .num_o(dv_n[g+1]), .rem_o(dv_r[g+1]), .quo_o(dv_q[g+1]),
      .pay_o(dv_p[g+1]));
  end

  function automatic logic signed [DW-1:0] qs(input logic neg, input logic [NW-1:0] m);
    if (m > NW'(MaxV)) return neg ? MinV : MaxV;
    return neg ? DW'(-m) : DW'(m);
  endfunction

  // output stage
  logic [PW-1:0] fp;
  logic [2:0]    fs;
  logic [YW-1:0] fr;
  logic signed [DW-1:0] qo [4];
  logic signed [DW-1:0] mainv;
  logic [2:0] midx;
  assign fp = dv_p[NW][PW+YW+2 -: PW];
  assign fr = dv_p[NW][YW+2:3];
  assign fs = dv_p[NW][2:0];
  assign midx = fp[5:3];
  always_comb begin
    int j;
    j = 0;
    mainv = ((YW-1) > (DW-1)) && ((fr >> 1) > YW'(MaxV)) ? MaxV : DW'(fr >> 1);
    for (int k = 0; k < 4; k++) qo[k] = '0;
    if (fp[PW-3*EW-1 -: 3] == rmq_pkg::PathIdent) begin
      qo[0] = (FB >= DW-1) ? MaxV : DW'(OneE);
    end else if (!fp[2]) begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) == midx) qo[k] = mainv;
        else begin
          qo[k] = qs(fs[j], dv_q[NW][j*NW +: NW]);
          j = j + 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= dv_v[NW];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_w_o <= qo[0];
      quat_x_o <= qo[1];
      quat_y_o <= qo[2];
      quat_z_o <= qo[3];
      path_o <= fp[PW-3*EW-1 -: 3];
      degenerate_o <= fp[2];
    end
  end
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the rotation matrix to quaternion core.
`timescale 1ns / 1ps
module testbench;

  localparam int  Dw      = rmq_pkg::DataWidth;
  localparam longint One = longint'(1) << rmq_pkg::FracBits;
  localparam longint MaxV = (longint'(1) << (Dw - 1)) - 1;
  localparam longint MinV = -(longint'(1) << (Dw - 1));

  typedef logic [11:0][Dw-1:0] matrix_t;
  typedef struct packed {
    logic [Dw-1:0] w;
    logic [Dw-1:0] x;
    logic [Dw-1:0] y;
    logic [Dw-1:0] z;
    logic [2:0]    path;
    logic          degenerate;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [Dw-1:0] m_in [12];
  wire in_stall, out_valid;
  wire signed [Dw-1:0] qw, qx, qy, qz;
  wire [2:0] path;
  wire degenerate;

  matrix_t pending_matrices [$];
  quat_t expected_quats [$];
  matrix_t cur;
  int unsigned in_gap = 0, out_gap = 0, mismatches = 0;

  always #5 clk_i = ~clk_i;

  initial for (int i = 0; i < 12; i++) m_in[i] = '0;

  rotation_matrix_to_quaternion_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .m00_i(m_in[0]), .m01_i(m_in[1]), .m02_i(m_in[2]),
    .m10_i(m_in[3]), .m11_i(m_in[4]), .m12_i(m_in[5]),
    .m20_i(m_in[6]), .m21_i(m_in[7]), .m22_i(m_in[8]),
    .scale_x_i(m_in[9]), .scale_y_i(m_in[10]), .scale_z_i(m_in[11]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .quat_w_o(qw), .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz),
    .path_o(path), .degenerate_o(degenerate)
  );

  function automatic longint clamp(longint v);
    return v > MaxV ? MaxV : (v < MinV ? MinV : v);
  endfunction

  function automatic longint scaled(logic [Dw-1:0] p, logic [Dw-1:0] q);
    longint a, b, m;
    a = longint'($signed(p));
    b = longint'($signed(q));
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> rmq_pkg::FracBits;
    return clamp(((a < 0) != (b < 0)) ? -m : m);
  endfunction

  function automatic longint root_of(longint r);
    longint unsigned t, y, c;
    t = longint'(r) << rmq_pkg::FracBits;
    y = 0;
    for (int b = 31; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (c * c <= t) y = c;
    end
    return longint'(y);
  endfunction

  function automatic longint divided(longint d, longint s);
    longint q;
    if (s == 0) return 0;
    q = ((d < 0 ? -d : d) << rmq_pkg::FracBits) / s;
    return clamp(d < 0 ? -q : q);
  endfunction

  function automatic quat_t quaternion_of(matrix_t mt);
    longint e [9];
    longint q [4];
    longint tr, rad, root, s;
    longint d [3];
    int hi;
    int j;
    quat_t r;
    for (int i = 0; i < 9; i++) e[i] = scaled(mt[i], mt[9 + i % 3]);
    q = '{0, 0, 0, 0};
    r.degenerate = 1'b0;
    tr = e[0] + e[4] + e[8];
    if (e[0] == One && e[4] == One && e[8] == One) begin
      r.path = rmq_pkg::PathIdent;
      q[0] = clamp(One);
    end else begin
      if (tr >= 0) begin
        r.path = rmq_pkg::PathTrace; hi = 0; rad = tr + One;
        d = '{e[7] - e[5], e[2] - e[6], e[3] - e[1]};
      end else if (e[0] > e[4] && e[0] > e[8]) begin
        r.path = rmq_pkg::PathX; hi = 1; rad = One + e[0] - e[4] - e[8];
        d = '{e[7] - e[5], e[1] + e[3], e[6] + e[2]};
      end else if (e[4] > e[8]) begin
        r.path = rmq_pkg::PathY; hi = 2; rad = One - e[0] + e[4] - e[8];
        d = '{e[2] - e[6], e[1] + e[3], e[5] + e[7]};
      end else begin
        r.path = rmq_pkg::PathZ; hi = 3; rad = One - e[0] - e[4] + e[8];
        d = '{e[3] - e[1], e[6] + e[2], e[5] + e[7]};
      end
      if (rad <= 0) begin
        r.degenerate = 1'b1;
      end else begin
        root = root_of(rad);
        s = root << 1;
        j = 0;
        for (int k = 0; k < 4; k++) begin
          if (k == hi) begin
            q[k] = clamp(root >> 1);
          end else begin
            q[k] = divided(d[j], s);
            j++;
          end
        end
      end
    end
    r.w = q[0][Dw-1:0];
    r.x = q[1][Dw-1:0];
    r.y = q[2][Dw-1:0];
    r.z = q[3][Dw-1:0];
    return r;
  endfunction

  function automatic void add_matrix(longint v [12]);
    matrix_t mt;
    for (int i = 0; i < 12; i++) mt[i] = v[i][Dw-1:0];
    pending_matrices.push_back(mt);
  endfunction

  function automatic longint near(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_quats.push_back(quaternion_of(cur));
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_matrices.size() > 50 && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending_matrices.size() != 0) begin
        cur = pending_matrices.pop_front();
        for (int i = 0; i < 12; i++) m_in[i] <= cur[i];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t exp_q;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: w=%h x=%h y=%h z=%h", qw, qx, qy, qz);
        end else begin
          exp_q = expected_quats.pop_front();
          if (qw !== exp_q.w || qx !== exp_q.x || qy !== exp_q.y || qz !== exp_q.z ||
              path !== exp_q.path || degenerate !== exp_q.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp w=%h x=%h y=%h z=%h p=%0d d=%b, got w=%h x=%h y=%h z=%h p=%0d d=%b",
                       exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.path, exp_q.degenerate,
                       qw, qx, qy, qz, path, degenerate);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (pending_matrices.size() > 50 && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    longint v [12];
    int kind;
    // identity, tie, branch and saturation corners
    add_matrix('{One, 0, 0, 0, One, 0, 0, 0, One, One, One, One});
    add_matrix('{One / 2, 0, 0, 0, One / 2, 0, 0, 0, One / 2, 2 * One, 2 * One, 2 * One});
    add_matrix('{One, 0, 0, 0, One, 0, 0, 0, One, One, One, One - 1});
    add_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_matrix('{One, 5, -7, 9, -One, 11, -13, 15, -One, One, One, One});
    add_matrix('{-One, 5, 7, 9, One, -11, 13, 15, -One, One, One, One});
    add_matrix('{-One, -5, 7, 9, -One, 11, 13, 15, One, One, One, One});
    add_matrix('{-One, 3, 4, 5, -One, 6, 7, 8, -One, One, One, One});
    add_matrix('{-One, 3, 4, 5, -One, 6, 7, 8, -2 * One, One, One, One});
    add_matrix('{-One / 2, 0, 0, 0, -One, 0, 0, 0, -One, One, One, One});
    add_matrix('{0, One, 0, -One, 0, 0, 0, 0, One, One, One, One});
    for (int i = 0; i < 12; i++) v[i] = MaxV;
    add_matrix(v);
    for (int i = 0; i < 12; i++) v[i] = MinV;
    add_matrix(v);
    for (int i = 0; i < 12; i++) v[i] = (i % 2) ? MinV : MaxV;
    add_matrix(v);
    for (int i = 0; i < 12; i++) v[i] = (i % 2) ? MaxV : MinV;
    add_matrix(v);
    add_matrix('{MinV, MaxV, MinV, MaxV, MinV, MaxV, MaxV, MinV, MinV, MaxV, MaxV, MaxV});
    add_matrix('{MinV, 1, -1, 1, MinV, -1, 1, -1, MaxV, MinV, MinV, MinV});
    add_matrix('{-One, MaxV, MinV, MinV, -One, MaxV, MaxV, MinV, -One, One, One, One});
    add_matrix('{1, -1, 1, -1, 1, -1, 1, -1, 1, 1, -1, 1});
    for (int n = 0; n < 400; n++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < 12; i++) begin
        case (kind)
          0: v[i] = longint'($signed(Dw'($urandom())));
          1: v[i] = (i < 9) ? near(One) : One + near(One / 8);
          2: v[i] = (i < 9) ? near(4 * One) : near(2 * One);
          default: v[i] = (i == 0 || i == 4 || i == 8) ? -near(One) - One / 2 :
                          (i < 9 ? near(One / 4) : One);
        endcase
      end
      add_matrix(v);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_matrices.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
